/* sv/ppsdb_pkg.sv */
// Package for the planar pixel store with dirty-box tracking.
// Holds screen geometry, request codes and the result record type.
// No dependencies.
package ppsdb_pkg;

    localparam int SCREEN_COLS = 640;
    localparam int SCREEN_ROWS = 480;
    localparam int ROW_BYTES   = (SCREEN_COLS + 7) / 8;
    localparam int STORE_WORDS = ROW_BYTES * SCREEN_ROWS;

    localparam int ADDR_W = $clog2(STORE_WORDS);
    localparam int COL_W  = 10;
    localparam int ROW_W  = 9;

    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_CLEAR = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;
    localparam logic [1:0] REQ_FLUSH = 2'd3;

    typedef struct packed {
        logic [7:0] plane0_byte;
        logic [7:0] plane1_byte;
        logic [7:0] plane2_byte;
        logic [7:0] plane3_byte;
        logic       pixel_accepted;
        logic       region_nonempty;
        logic [6:0] region_first_col_byte;
        logic [6:0] region_col_bytes;
        logic [8:0] region_first_row;
        logic [8:0] region_end_row;
    } result_t;

    // Expand a 4-bit color into one full byte per plane.
    function automatic logic [31:0] fill_word(input logic [3:0] color);
        logic [31:0] w;
        w = '0;
        for (int n = 0; n < 4; n++) begin
            if (color[n]) begin
                w[8*n +: 8] = 8'hFF;
            end
        end
        return w;
    endfunction

endpackage

/* sv/planar_pixel_store_dirty_box_core.sv */
// Top level of the planar pixel store with dirty-box tracking.
// One 38400 x 32 synchronous RAM holds the four planes; uses ppsdb_pkg.
// Each input transaction does a registered RAM read, then the modify/write and result register update;
// the finish waits until the result register is free, and no new transaction is taken until it is done.
// A clear then runs a fill sweep over all 38400 words, input stalled meanwhile.
// Reset (aresetn low, synchronous) starts a zeroing sweep of all 38400 words; s_ready stays low.
module planar_pixel_store_dirty_box_core
    import ppsdb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic signed [11:0] s_pixel_x,
    input  logic signed [11:0] s_pixel_y,
    input  logic [3:0]  s_pen_color,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_plane0_byte,
    output logic [7:0]  m_plane1_byte,
    output logic [7:0]  m_plane2_byte,
    output logic [7:0]  m_plane3_byte,
    output logic        m_pixel_accepted,
    output logic        m_region_nonempty,
    output logic [6:0]  m_region_first_col_byte,
    output logic [6:0]  m_region_col_bytes,
    output logic [8:0]  m_region_first_row,
    output logic [8:0]  m_region_end_row
);

    // Sequencer states
    localparam logic [1:0] ST_SWEEP = 2'd0;  // fill the whole store from fill_reg
    localparam logic [1:0] ST_IDLE  = 2'd1;  // wait for an input transaction
    localparam logic [1:0] ST_DONE  = 2'd2;  // RAM data ready; finish and post result

    // Plane store: bits 8n+7..8n hold plane n, bit 7 of a byte is leftmost
    logic [31:0] mem [STORE_WORDS];
    logic [31:0] mem_rdata_reg;

    logic [1:0]        state_reg, state_next;
    logic [ADDR_W-1:0] sweep_addr_reg, sweep_addr_next;
    logic [31:0]       fill_reg, fill_next;

    // Latched request
    logic [1:0]        req_type_reg;
    logic              on_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [COL_W-1:0]  px_reg;
    logic [ROW_W-1:0]  py_reg;
    logic [3:0]        color_reg;

    // Dirty box, right and bottom exclusive
    logic              dirty_reg, dirty_next;
    logic [COL_W-1:0]  box_left_reg, box_left_next;
    logic [ROW_W-1:0]  box_top_reg, box_top_next;
    logic [COL_W-1:0]  box_right_reg, box_right_next;
    logic [ROW_W-1:0]  box_bottom_reg, box_bottom_next;

    // Result register
    logic              m_valid_reg, m_valid_next;
    result_t           out_reg, out_next;

    logic              accept;
    logic              out_free;
    logic              on_x, on_y;
    logic [ADDR_W-1:0] in_addr;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [31:0]       mem_wdata;
    logic [31:0]       new_word;
    logic [7:0]        pix_mask;

    logic [COL_W-1:0]  px_inc;
    logic [ROW_W-1:0]  py_inc;
    logic [COL_W:0]    end_col_sum;
    logic [6:0]        first_col_byte;
    logic [6:0]        end_col_byte;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // On-screen test and word address of the pixel's byte
    assign on_x = !s_pixel_x[11] && (s_pixel_x[10:0] < 11'(SCREEN_COLS));
    assign on_y = !s_pixel_y[11] && (s_pixel_y[10:0] < 11'(SCREEN_ROWS));
    assign in_addr = ADDR_W'(ADDR_W'(s_pixel_y[ROW_W-1:0]) * ADDR_W'(ROW_BYTES))
                   + ADDR_W'(s_pixel_x[COL_W-1:3]);

    // Set or clear the pixel bit in every plane from the pen color
    assign pix_mask = 8'h80 >> px_reg[2:0];
    always_comb begin
        for (int n = 0; n < 4; n++) begin
            if (color_reg[n]) begin
                new_word[8*n +: 8] = mem_rdata_reg[8*n +: 8] | pix_mask;
            end else begin
                new_word[8*n +: 8] = mem_rdata_reg[8*n +: 8] & ~pix_mask;
            end
        end
    end

    assign px_inc = px_reg + COL_W'(1);
    assign py_inc = py_reg + ROW_W'(1);

    // Byte-aligned flush region
    assign end_col_sum    = (COL_W+1)'(box_right_reg) + (COL_W+1)'(7);
    assign first_col_byte = 7'(box_left_reg >> 3);
    assign end_col_byte   = 7'(end_col_sum >> 3);

    always_comb begin
        state_next      = state_reg;
        sweep_addr_next = sweep_addr_reg;
        fill_next       = fill_reg;
        dirty_next      = dirty_reg;
        box_left_next   = box_left_reg;
        box_top_next    = box_top_reg;
        box_right_next  = box_right_reg;
        box_bottom_next = box_bottom_reg;
        m_valid_next    = m_valid_reg;
        out_next        = out_reg;
        mem_we          = 1'b0;
        mem_waddr       = addr_reg;
        mem_wdata       = new_word;

        // Drop the result once the sink takes it
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_SWEEP: begin
                mem_we    = 1'b1;
                mem_waddr = sweep_addr_reg;
                mem_wdata = fill_reg;
                if (sweep_addr_reg == ADDR_W'(STORE_WORDS - 1)) begin
                    state_next = ST_IDLE;
                end else begin
                    sweep_addr_next = sweep_addr_reg + ADDR_W'(1);
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // Hold here until the result register can take the transaction
                if (out_free) begin
                    m_valid_next = 1'b1;
                    out_next     = '0;
                    state_next   = ST_IDLE;
                    case (req_type_reg)
                        REQ_WRITE: begin
                            if (on_reg) begin
                                mem_we                  = 1'b1;
                                out_next.pixel_accepted = 1'b1;
                                dirty_next              = 1'b1;
                                if (!dirty_reg) begin
                                    box_left_next   = px_reg;
                                    box_top_next    = py_reg;
                                    box_right_next  = px_inc;
                                    box_bottom_next = py_inc;
                                end else begin
                                    if (px_reg < box_left_reg)   box_left_next   = px_reg;
                                    if (py_reg < box_top_reg)    box_top_next    = py_reg;
                                    if (px_inc > box_right_reg)  box_right_next  = px_inc;
                                    if (py_inc > box_bottom_reg) box_bottom_next = py_inc;
                                end
                            end
                        end
                        REQ_CLEAR: begin
                            fill_next       = fill_word(color_reg);
                            sweep_addr_next = '0;
                            state_next      = ST_SWEEP;
                            dirty_next      = 1'b1;
                            box_left_next   = '0;
                            box_top_next    = '0;
                            box_right_next  = COL_W'(SCREEN_COLS);
                            box_bottom_next = ROW_W'(SCREEN_ROWS);
                        end
                        REQ_READ: begin
                            if (on_reg) begin
                                out_next.plane0_byte    = mem_rdata_reg[7:0];
                                out_next.plane1_byte    = mem_rdata_reg[15:8];
                                out_next.plane2_byte    = mem_rdata_reg[23:16];
                                out_next.plane3_byte    = mem_rdata_reg[31:24];
                                out_next.pixel_accepted = 1'b1;
                            end
                        end
                        REQ_FLUSH: begin
                            if (dirty_reg) begin
                                if (box_left_reg < box_right_reg &&
                                    box_top_reg < box_bottom_reg) begin
                                    out_next.region_nonempty       = 1'b1;
                                    out_next.region_first_col_byte = first_col_byte;
                                    out_next.region_col_bytes      =
                                        end_col_byte - first_col_byte;
                                    out_next.region_first_row      = box_top_reg;
                                    out_next.region_end_row        = box_bottom_reg;
                                end
                                dirty_next = 1'b0;
                            end
                        end
                        default: begin
                            out_next = '0;
                        end
                    endcase
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Plane store RAM: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (accept) begin
            mem_rdata_reg <= mem[in_addr];
        end
    end

    // Request capture
    always_ff @(posedge aclk) begin
        if (accept) begin
            req_type_reg <= s_req_type;
            on_reg       <= on_x && on_y;
            addr_reg     <= in_addr;
            px_reg       <= s_pixel_x[COL_W-1:0];
            py_reg       <= s_pixel_y[ROW_W-1:0];
            color_reg    <= s_pen_color;
        end
        out_reg <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_SWEEP;
            sweep_addr_reg <= '0;
            fill_reg       <= '0;
            dirty_reg      <= 1'b0;
            box_left_reg   <= COL_W'(SCREEN_COLS);
            box_top_reg    <= ROW_W'(SCREEN_ROWS);
            box_right_reg  <= '0;
            box_bottom_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            sweep_addr_reg <= sweep_addr_next;
            fill_reg       <= fill_next;
            dirty_reg      <= dirty_next;
            box_left_reg   <= box_left_next;
            box_top_reg    <= box_top_next;
            box_right_reg  <= box_right_next;
            box_bottom_reg <= box_bottom_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    assign m_valid                 = m_valid_reg;
    assign m_plane0_byte           = out_reg.plane0_byte;
    assign m_plane1_byte           = out_reg.plane1_byte;
    assign m_plane2_byte           = out_reg.plane2_byte;
    assign m_plane3_byte           = out_reg.plane3_byte;
    assign m_pixel_accepted        = out_reg.pixel_accepted;
    assign m_region_nonempty       = out_reg.region_nonempty;
    assign m_region_first_col_byte = out_reg.region_first_col_byte;
    assign m_region_col_bytes      = out_reg.region_col_bytes;
    assign m_region_first_row      = out_reg.region_first_row;
    assign m_region_end_row        = out_reg.region_end_row;

    // An accepted transaction always moves to the finishing state
    a_accept_to_done: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == ST_DONE))
        else $error("accepted transaction did not advance to finish");

    // The RAM is only written while finishing a write or sweeping
    a_we_state: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg == ST_SWEEP || state_reg == ST_DONE))
        else $error("RAM write outside finish or sweep");

    // Finishing with a free result register posts a result
    a_done_posts: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && out_free) |=> m_valid_reg)
        else $error("finished transaction posted no result");

    // A reported region is never empty
    a_region_sane: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_reg.region_nonempty) |->
            (out_reg.region_end_row > out_reg.region_first_row &&
             out_reg.region_col_bytes != 7'd0))
        else $error("nonempty flag with empty region");

    // The sweep ends after the last word
    a_sweep_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SWEEP && sweep_addr_reg == ADDR_W'(STORE_WORDS - 1))
            |=> (state_reg == ST_IDLE))
        else $error("sweep did not end at the last word");

endmodule

/* tb/sv/planar_pixel_store_dirty_box_core_test.sv */
// Self-checking testbench for planar_pixel_store_dirty_box_core: directed table, then random
// pixel traffic, checked against a plane-store and dirty-box predictor kept in the bench.
// Depends on ppsdb_pkg (geometry, request codes, result_t) and the core itself.
module planar_pixel_store_dirty_box_core_test;
    import ppsdb_pkg::*;

    // Zeroing and clear sweeps keep s_ready low for a whole store pass; allow several.
    localparam int IDLE_LIMIT     = 4 * STORE_WORDS + 4000;
    localparam int RANDOM_ITEMS   = 500;
    localparam int MAX_CLEARS     = 8;
    localparam int HOLD_OFF_AFTER = 80;
    localparam int HOLD_OFF_LEN   = 400;
    localparam int DRAIN_CYCLES   = 20;
    localparam int REPORT_LIMIT   = 200;

    typedef struct {
        logic [1:0]        req;
        logic signed [11:0] x;
        logic signed [11:0] y;
        logic [3:0]        color;
        bit                typed;
        result_t           want;
    } pixel_req_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_req_type;
    logic signed [11:0] s_pixel_x;
    logic signed [11:0] s_pixel_y;
    logic [3:0]  s_pen_color;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_plane0_byte;
    logic [7:0]  m_plane1_byte;
    logic [7:0]  m_plane2_byte;
    logic [7:0]  m_plane3_byte;
    logic        m_pixel_accepted;
    logic        m_region_nonempty;
    logic [6:0]  m_region_first_col_byte;
    logic [6:0]  m_region_col_bytes;
    logic [8:0]  m_region_first_row;
    logic [8:0]  m_region_end_row;

    // Shadow of the frame store and the dirty box.
    logic [31:0] shadow_planes [STORE_WORDS];
    bit          shadow_dirty;
    logic [9:0]  shadow_left;
    logic [8:0]  shadow_top;
    logic [9:0]  shadow_right;
    logic [8:0]  shadow_bottom;

    pixel_req_t  request_list [$];
    result_t     pending_results [$];
    int          mismatches = 0;
    int          n_accepted;
    bit          held_off;

    planar_pixel_store_dirty_box_core i_dut (
        .aclk                    (aclk),
        .aresetn                 (aresetn),
        .s_valid                 (s_valid),
        .s_ready                 (s_ready),
        .s_req_type              (s_req_type),
        .s_pixel_x               (s_pixel_x),
        .s_pixel_y               (s_pixel_y),
        .s_pen_color             (s_pen_color),
        .m_valid                 (m_valid),
        .m_ready                 (m_ready),
        .m_plane0_byte           (m_plane0_byte),
        .m_plane1_byte           (m_plane1_byte),
        .m_plane2_byte           (m_plane2_byte),
        .m_plane3_byte           (m_plane3_byte),
        .m_pixel_accepted        (m_pixel_accepted),
        .m_region_nonempty       (m_region_nonempty),
        .m_region_first_col_byte (m_region_first_col_byte),
        .m_region_col_bytes      (m_region_col_bytes),
        .m_region_first_row      (m_region_first_row),
        .m_region_end_row        (m_region_end_row)
    );

    initial aclk = 1'b0;
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Apply one accepted request to the shadow state and return the result it should give.
    function automatic result_t predict_frame_result(input logic [1:0] req,
                                                     input logic signed [11:0] x,
                                                     input logic signed [11:0] y,
                                                     input logic [3:0] color);
        result_t     r;
        bit          on;
        int          idx;
        int          bit_pos;
        int          r_edge;
        int          b_edge;
        int          first;
        int          last_end;
        logic [31:0] w;
        r  = '0;
        on = (x >= 0) && (x < SCREEN_COLS) && (y >= 0) && (y < SCREEN_ROWS);
        idx = 0;
        if (on) begin
            idx = int'(y) * ROW_BYTES + int'(x) / 8;
            if (idx >= STORE_WORDS) begin
                on = 1'b0;
            end
        end
        case (req)
            REQ_WRITE: begin
                if (on) begin
                    // Bit 7 of each plane byte is the leftmost pixel.
                    w = shadow_planes[idx];
                    bit_pos = 7 - int'(x[2:0]);
                    for (int n = 0; n < 4; n++) begin
                        w[8*n + bit_pos] = color[n];
                    end
                    shadow_planes[idx] = w;
                    if (!shadow_dirty) begin
                        shadow_left   = x[9:0];
                        shadow_top    = y[8:0];
                        shadow_right  = x[9:0] + 10'd1;
                        shadow_bottom = y[8:0] + 9'd1;
                        shadow_dirty  = 1'b1;
                    end else begin
                        if (x[9:0] < shadow_left) shadow_left = x[9:0];
                        if (y[8:0] < shadow_top) shadow_top = y[8:0];
                        if (x[9:0] + 10'd1 > shadow_right) shadow_right = x[9:0] + 10'd1;
                        if (y[8:0] + 9'd1 > shadow_bottom) shadow_bottom = y[8:0] + 9'd1;
                    end
                    r.pixel_accepted = 1'b1;
                end
            end
            REQ_CLEAR: begin
                w = {{8{color[3]}}, {8{color[2]}}, {8{color[1]}}, {8{color[0]}}};
                for (int i = 0; i < STORE_WORDS; i++) begin
                    shadow_planes[i] = w;
                end
                shadow_left   = '0;
                shadow_top    = '0;
                shadow_right  = 10'(SCREEN_COLS);
                shadow_bottom = 9'(SCREEN_ROWS);
                shadow_dirty  = 1'b1;
            end
            REQ_READ: begin
                if (on) begin
                    w = shadow_planes[idx];
                    r.plane0_byte    = w[7:0];
                    r.plane1_byte    = w[15:8];
                    r.plane2_byte    = w[23:16];
                    r.plane3_byte    = w[31:24];
                    r.pixel_accepted = 1'b1;
                end
            end
            default: begin
                if (shadow_dirty) begin
                    r_edge = (shadow_right > SCREEN_COLS) ? SCREEN_COLS : int'(shadow_right);
                    b_edge = (shadow_bottom > SCREEN_ROWS) ? SCREEN_ROWS : int'(shadow_bottom);
                    shadow_right  = 10'(r_edge);
                    shadow_bottom = 9'(b_edge);
                    if (shadow_left < r_edge && shadow_top < b_edge) begin
                        first    = int'(shadow_left) / 8;
                        last_end = (r_edge + 7) / 8;
                        r.region_nonempty       = 1'b1;
                        r.region_first_col_byte = first[6:0];
                        r.region_col_bytes      = 7'(last_end - first);
                        r.region_first_row      = shadow_top;
                        r.region_end_row        = b_edge[8:0];
                    end
                    shadow_dirty = 1'b0;
                end
            end
        endcase
        return r;
    endfunction

    function automatic result_t plane_result(input logic [7:0] p0, input logic [7:0] p1,
                                             input logic [7:0] p2, input logic [7:0] p3,
                                             input logic acc);
        result_t r;
        r = '0;
        r.plane0_byte    = p0;
        r.plane1_byte    = p1;
        r.plane2_byte    = p2;
        r.plane3_byte    = p3;
        r.pixel_accepted = acc;
        return r;
    endfunction

    function automatic result_t region_result(input logic [6:0] first_col, input logic [6:0] cols,
                                              input logic [8:0] first_row,
                                              input logic [8:0] end_row);
        result_t r;
        r = '0;
        r.region_nonempty       = 1'b1;
        r.region_first_col_byte = first_col;
        r.region_col_bytes      = cols;
        r.region_first_row      = first_row;
        r.region_end_row        = end_row;
        return r;
    endfunction

    task automatic add_row(input logic [1:0] req, input logic signed [11:0] x,
                           input logic signed [11:0] y, input logic [3:0] color,
                           input bit typed, input result_t want);
        pixel_req_t row;
        row.req   = req;
        row.x     = x;
        row.y     = y;
        row.color = color;
        row.typed = typed;
        row.want  = want;
        request_list.push_back(row);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            // Drop reports past the limit so a broken build does not flood the log.
            if (mismatches < REPORT_LIMIT) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
            mismatches++;
        end
    endtask

    // Directed table. Rows marked typed carry a hand-written expectation; the rest are
    // checked against the predictor.
    task automatic build_directed();
        // After reset the store is zero and the box is clean.
        add_row(REQ_READ,  0, 0, 4'd7, 1, plane_result(0, 0, 0, 0, 1));
        add_row(REQ_FLUSH, 0, 0, 4'd0, 1, '0);
        // Off-screen writes past the left, right and bottom edges and at the field extremes.
        add_row(REQ_WRITE, -1, 0, 4'd15, 1, '0);
        add_row(REQ_WRITE, 640, 0, 4'd15, 1, '0);
        add_row(REQ_WRITE, 0, 480, 4'd15, 1, '0);
        add_row(REQ_WRITE, 2047, 2047, 4'd15, 1, '0);
        add_row(REQ_WRITE, -2048, -2048, 4'd15, 1, '0);
        // Off-screen reads.
        add_row(REQ_READ, -2048, 100, 4'd15, 1, '0);
        add_row(REQ_READ, 100, -1, 4'd15, 1, '0);
        // Opposite corners, then read them back.
        add_row(REQ_WRITE, 0, 0, 4'd15, 1, plane_result(0, 0, 0, 0, 1));
        add_row(REQ_WRITE, 639, 479, 4'd5, 1, plane_result(0, 0, 0, 0, 1));
        add_row(REQ_READ, 0, 0, 4'd0, 1, plane_result(8'h80, 8'h80, 8'h80, 8'h80, 1));
        add_row(REQ_READ, 639, 479, 4'd15, 1, plane_result(8'h01, 8'h00, 8'h01, 8'h00, 1));
        add_row(REQ_FLUSH, 0, 0, 4'd0, 1, region_result(0, 80, 0, 480));
        // Flush while clean.
        add_row(REQ_FLUSH, 5, 5, 4'd3, 1, '0);
        // First write after a flush: the box is exactly that pixel.
        add_row(REQ_WRITE, 13, 7, 4'd10, 1, plane_result(0, 0, 0, 0, 1));
        add_row(REQ_FLUSH, 0, 0, 4'd0, 1, region_result(1, 1, 7, 8));
        add_row(REQ_WRITE, 100, 200, 4'd3, 0, '0);
        add_row(REQ_WRITE, 37, 300, 4'd12, 0, '0);
        add_row(REQ_FLUSH, 0, 0, 4'd0, 0, '0);
        // Clear ignores the coordinates and marks the whole screen dirty.
        add_row(REQ_CLEAR, -2048, 2047, 4'd9, 1, '0);
        add_row(REQ_READ, 320, 240, 4'd0, 1, plane_result(8'hFF, 8'h00, 8'h00, 8'hFF, 1));
        add_row(REQ_FLUSH, -1, -1, 4'd15, 1, region_result(0, 80, 0, 480));
        add_row(REQ_CLEAR, 2047, -2048, 4'd0, 1, '0);
        add_row(REQ_READ, 320, 240, 4'd15, 0, '0);
        add_row(REQ_FLUSH, 0, 0, 4'd0, 0, '0);
    endtask

    // Random part: mostly on-screen writes and reads with regular flushes, some
    // off-screen noise, and a handful of clears since each one sweeps the store.
    task automatic build_random();
        int                 pick;
        int                 n_clears;
        logic [1:0]         req;
        logic signed [11:0] x;
        logic signed [11:0] y;
        logic signed [11:0] last_x;
        logic signed [11:0] last_y;
        logic [3:0]         color;
        n_clears = 0;
        last_x   = 0;
        last_y   = 0;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            pick  = $urandom_range(0, 199);
            color = 4'($urandom_range(0, 15));
            if (pick < 2) begin
                req = (n_clears < MAX_CLEARS) ? REQ_CLEAR : REQ_WRITE;
            end else if (pick < 112) begin
                req = REQ_WRITE;
            end else if (pick < 172) begin
                req = REQ_READ;
            end else begin
                req = REQ_FLUSH;
            end
            if (req == REQ_CLEAR) begin
                n_clears++;
            end
            if (req == REQ_CLEAR || req == REQ_FLUSH || $urandom_range(0, 99) < 15) begin
                x = 12'($urandom_range(0, 4095));
                y = 12'($urandom_range(0, 4095));
            end else if (req == REQ_READ && $urandom_range(0, 1) == 1) begin
                // Hit the byte of the latest write.
                x = last_x ^ 12'($urandom_range(0, 7));
                y = last_y;
            end else if ($urandom_range(0, 99) < 60) begin
                x = 12'($urandom_range(0, SCREEN_COLS - 1));
                y = 12'($urandom_range(0, SCREEN_ROWS - 1));
            end else begin
                x = 12'($urandom_range(200, 263));
                y = 12'($urandom_range(100, 131));
            end
            if (req == REQ_WRITE && x >= 0 && x < SCREEN_COLS && y >= 0 && y < SCREEN_ROWS) begin
                last_x = x;
                last_y = y;
            end
            add_row(req, x, y, color, 0, '0);
        end
    endtask

    // Sender: reset, then bursts of transactions separated by random gaps.
    initial begin
        int         idx;
        int         burst;
        int         gap;
        pixel_req_t row;
        result_t    predicted;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_req_type  = REQ_WRITE;
        s_pixel_x   = '0;
        s_pixel_y   = '0;
        s_pen_color = '0;
        n_accepted  = 0;
        shadow_dirty  = 1'b0;
        shadow_left   = 10'(SCREEN_COLS);
        shadow_top    = 9'(SCREEN_ROWS);
        shadow_right  = '0;
        shadow_bottom = '0;
        for (int i = 0; i < STORE_WORDS; i++) begin
            shadow_planes[i] = '0;
        end
        build_directed();
        build_random();

        repeat (12) @(negedge aclk);
        aresetn = 1'b1;

        idx = 0;
        while (idx < request_list.size()) begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst && idx < request_list.size(); k++) begin
                row         = request_list[idx];
                s_valid     = 1'b1;
                s_req_type  = row.req;
                s_pixel_x   = row.x;
                s_pixel_y   = row.y;
                s_pen_color = row.color;
                // Hold the payload until the block takes it.
                do @(posedge aclk); while (!s_ready);
                predicted = predict_frame_result(row.req, row.x, row.y, row.color);
                pending_results.push_back(row.typed ? row.want : predicted);
                n_accepted++;
                idx++;
                @(negedge aclk);
            end
            gap = ($urandom_range(0, 99) < 40) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_valid = 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        s_valid = 1'b0;

        // Drain, then give the block a few more cycles to show any stray result.
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("** planar_pixel_store_dirty_box_core: PASSED **");
        end else begin
            $display("** planar_pixel_store_dirty_box_core: FAILED **");
        end
        $finish;
    end

    // Receiver: rotate between always ready, coin-flip stalls and a fixed 3-of-5
    // pattern. Once, early in the random part, hold off long enough to back the
    // block up into its input.
    initial begin
        int cyc;
        cyc      = 0;
        held_off = 1'b0;
        m_ready  = 1'b0;
        forever begin
            @(negedge aclk);
            cyc++;
            if (!held_off && n_accepted >= HOLD_OFF_AFTER) begin
                m_ready = 1'b0;
                repeat (HOLD_OFF_LEN) @(negedge aclk);
                held_off = 1'b1;
            end else begin
                case ((cyc / 97) % 3)
                    0: begin
                        m_ready = 1'b1;
                    end
                    1: begin
                        m_ready = 1'($urandom_range(0, 1));
                    end
                    default: begin
                        m_ready = (cyc % 5) < 3;
                    end
                endcase
            end
        end
    end

    // Result checker: compare each result transaction with the oldest expectation.
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with no expectation pending, actual plane bytes %h %h %h %h",
                         $time, m_plane0_byte, m_plane1_byte, m_plane2_byte, m_plane3_byte);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                check_field("plane0_byte", 32'(want.plane0_byte), 32'(m_plane0_byte));
                check_field("plane1_byte", 32'(want.plane1_byte), 32'(m_plane1_byte));
                check_field("plane2_byte", 32'(want.plane2_byte), 32'(m_plane2_byte));
                check_field("plane3_byte", 32'(want.plane3_byte), 32'(m_plane3_byte));
                check_field("pixel_accepted", 32'(want.pixel_accepted),
                            32'(m_pixel_accepted));
                check_field("region_nonempty", 32'(want.region_nonempty),
                            32'(m_region_nonempty));
                check_field("region_first_col_byte", 32'(want.region_first_col_byte),
                            32'(m_region_first_col_byte));
                check_field("region_col_bytes", 32'(want.region_col_bytes),
                            32'(m_region_col_bytes));
                check_field("region_first_row", 32'(want.region_first_row),
                            32'(m_region_first_row));
                check_field("region_end_row", 32'(want.region_end_row),
                            32'(m_region_end_row));
            end
        end
    end

    // Watchdog: advance on cycles with no transaction on either channel.
    always @(posedge aclk) begin
        int idle_cycles;
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                         $time, IDLE_LIMIT, pending_results.size());
                $display("** planar_pixel_store_dirty_box_core: FAILED **");
                $finish;
            end
        end
    end

endmodule
